// File: rtl/core/kanji_card_bus_decoder_unit_macros.svh
// Assertion macros used by the bus decoder RTL.
`ifndef KANJI_CARD_BUS_DECODER_UNIT_MACROS_SVH
`define KANJI_CARD_BUS_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define KCBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define KCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/kcbd_pkg.sv
// Types and constants of the bus decoder.
`timescale 1ns / 1ps

package kcbd_pkg;

	localparam logic [1:0] OP_SUB_RD  = 2'd0;
	localparam logic [1:0] OP_SUB_WR  = 2'd1;
	localparam logic [1:0] OP_HOST_RD = 2'd2;
	localparam logic [1:0] OP_HOST_WR = 2'd3;

	localparam logic [1:0] ROM_NONE = 2'd0;
	localparam logic [1:0] ROM_MON  = 2'd1;
	localparam logic [1:0] ROM_DICT = 2'd2;

	localparam logic [15:0] ADDR_MON_BASE  = 16'hc000;
	localparam logic [15:0] ADDR_DICT_BASE = 16'ha000;
	localparam logic [15:0] ADDR_DICT_LAST = 16'hafff;
	localparam logic [15:0] ADDR_SRAM_BASE = 16'h8000;
	localparam logic [15:0] ADDR_SRAM_LAST = 16'h9ffe;
	localparam logic [15:0] ADDR_BANK_REG  = 16'h9fff;
	localparam logic [15:0] PORT_HALT_STAT = 16'hfd28;
	localparam logic [15:0] PORT_RCB_RD    = 16'hfd29;
	localparam logic [15:0] PORT_HALT_CTRL = 16'hfd2a;
	localparam logic [15:0] PORT_RCB_WR    = 16'hfd2b;

	localparam logic [15:0] RCB_WINDOW  = 16'h1f00;
	localparam logic [7:0]  BYTE_OPEN   = 8'hff;
	localparam logic [7:0]  HALT_ACTIVE = 8'h7f;

	typedef struct packed {
		logic       halted;
		logic [5:0] bank;
		logic [7:0] cnt;
	} kcbd_state_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        handled;
		logic [1:0]  rom_select;
		logic [17:0] rom_address;
		logic        ram_read;
	} kcbd_result_t;

	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [15:0] offset;
	} kcbd_ram_req_t;

endpackage

// File: rtl/core/kcbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kcbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/kcbd_decode.sv
// Address decode, register updates and SRAM request for one bus access.
`timescale 1ns / 1ps

module kcbd_decode (
	input  logic                   fm8,
	input  logic [1:0]             operation,
	input  logic [15:0]            address,
	input  logic [7:0]             write_data,
	input  kcbd_pkg::kcbd_state_t  cur,
	output kcbd_pkg::kcbd_state_t  nxt,
	output kcbd_pkg::kcbd_result_t res,
	output kcbd_pkg::kcbd_ram_req_t ram
);

	logic        live;
	logic        in_sram;
	logic [15:0] rcb_offset;

	assign live       = !fm8;
	assign in_sram    = (address >= kcbd_pkg::ADDR_SRAM_BASE) &&
		(address <= kcbd_pkg::ADDR_SRAM_LAST);
	assign rcb_offset = kcbd_pkg::RCB_WINDOW | {8'd0, cur.cnt};

	always_comb begin
		nxt             = cur;
		res.read_data   = kcbd_pkg::BYTE_OPEN;
		res.handled     = 1'b1;
		res.rom_select  = kcbd_pkg::ROM_NONE;
		res.rom_address = 18'd0;
		res.ram_read    = 1'b0;
		ram.rd          = 1'b0;
		ram.wr          = 1'b0;
		ram.offset      = address - kcbd_pkg::ADDR_SRAM_BASE;
		case (operation)
			kcbd_pkg::OP_SUB_RD: begin
				if (address >= kcbd_pkg::ADDR_MON_BASE) begin
					res.rom_select  = kcbd_pkg::ROM_MON;
					res.rom_address = {4'd0, address[13:0]};
				end else if ((address >= kcbd_pkg::ADDR_DICT_BASE) &&
						(address <= kcbd_pkg::ADDR_DICT_LAST)) begin
					res.rom_select  = kcbd_pkg::ROM_DICT;
					res.rom_address = {cur.bank, address[11:0]};
				end else if (in_sram) begin
					res.ram_read = 1'b1;
					ram.rd       = 1'b1;
				end else if (address == kcbd_pkg::ADDR_BANK_REG) begin
					res.read_data = {2'b00, cur.bank};
				end
			end
			kcbd_pkg::OP_SUB_WR: begin
				if (address == kcbd_pkg::ADDR_BANK_REG) begin
					nxt.halted = !write_data[7];
					nxt.bank   = write_data[5:0];
				end else if (in_sram) begin
					ram.wr = 1'b1;
				end
			end
			kcbd_pkg::OP_HOST_RD: begin
				if (address == kcbd_pkg::PORT_HALT_STAT) begin
					if (live && cur.halted) begin
						res.read_data = kcbd_pkg::HALT_ACTIVE;
					end
				end else if (address == kcbd_pkg::PORT_RCB_RD) begin
					if (live && cur.halted) begin
						res.ram_read = 1'b1;
						ram.rd       = 1'b1;
						ram.offset   = rcb_offset;
						nxt.cnt      = cur.cnt + 8'd1;
					end
				end else begin
					res.handled = 1'b0;
				end
			end
			default: begin
				if (address == kcbd_pkg::PORT_HALT_CTRL) begin
					if (live) begin
						nxt.halted = !write_data[7];
						if (!write_data[7]) begin
							nxt.cnt = 8'd0;
						end
					end
				end else if (address == kcbd_pkg::PORT_RCB_WR) begin
					if (live && cur.halted) begin
						ram.wr     = 1'b1;
						ram.offset = rcb_offset;
						nxt.cnt    = cur.cnt + 8'd1;
					end
				end else begin
					res.handled = 1'b0;
				end
			end
		endcase
	end

endmodule

// File: rtl/core/kanji_card_bus_decoder_unit.sv
// Top level of the dictionary card bus decoder: beat handshake, state and shared SRAM.
// A result beat appears in the output stage in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the SRAM has one write and one registered read port.
// A stalled result holds the single output stage and stops further input beats.
// Reset (arst_n low, asynchronous) clears halt, bank, stream counter, FM8 flag, valid.
// Shared SRAM contents are not reset and are undefined until written; no clearing pass.
`timescale 1ns / 1ps
`include "kanji_card_bus_decoder_unit_macros.svh"

module kanji_card_bus_decoder_unit #(
	parameter int SRAM_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: host_is_fm8 in bit 0.
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// Input beat.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // address [15:0], write_data [23:16]
	input  logic [1:0]  s_tuser,  // operation [1:0]
	// Result beat.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_data [7:0], rom_address [25:8], zero [31:26]
	output logic [2:0]  m_tuser   // handled [0], rom_select [2:1]
);

	localparam int AW = $clog2(SRAM_BYTES);

	logic                    fm8_q;
	kcbd_pkg::kcbd_state_t   state_q;
	kcbd_pkg::kcbd_state_t   state_nxt;
	kcbd_pkg::kcbd_result_t  res;
	kcbd_pkg::kcbd_ram_req_t ram_req;

	logic        valid_s1;
	logic [7:0]  rd_s1;
	logic        hit_s1;
	logic [1:0]  sel_s1;
	logic [17:0] radr_s1;
	logic        ram_use_s1;
	logic [7:0]  ram_rdata;
	logic        accept;

	// The single output stage frees up in the same cycle its beat is taken.
	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	kcbd_decode u_decode (
		.fm8        (fm8_q),
		.operation  (s_tuser),
		.address    (s_tdata[15:0]),
		.write_data (s_tdata[23:16]),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res),
		.ram        (ram_req)
	);

	// The SRAM reads only on an accepted beat, so its output register holds
	// the byte for as long as the result beat stalls.
	kcbd_ram #(
		.WIDTH (8),
		.DEPTH (SRAM_BYTES)
	) u_sram (
		.clk   (clk),
		.we    (accept && ram_req.wr),
		.waddr (ram_req.offset[AW-1:0]),
		.wdata (s_tdata[23:16]),
		.re    (accept && ram_req.rd),
		.raddr (ram_req.offset[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm8_q    <= 1'b0;
			state_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fm8_q <= cfg_wr_data;
			end
			if (accept) begin
				state_q <= state_nxt;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	// Result payload of the output stage; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1      <= res.read_data;
			hit_s1     <= res.handled;
			sel_s1     <= res.rom_select;
			radr_s1    <= res.rom_address;
			ram_use_s1 <= res.ram_read;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {6'd0, radr_s1, (ram_use_s1 ? ram_rdata : rd_s1)};
	assign m_tuser  = {sel_s1, hit_s1};

	// Every accepted beat shows up in the output stage in the next cycle.
	`KCBD_ASSERT_NEXT(a_accept_fills_stage, accept, valid_s1,
		"accepted beat did not reach the output stage")

	// A ROM read never carries a data byte of its own.
	`KCBD_ASSERT_NOW(a_rom_read_open_bus, valid_s1 && (sel_s1 != kcbd_pkg::ROM_NONE),
		(m_tdata[7:0] == kcbd_pkg::BYTE_OPEN) && !ram_use_s1,
		"ROM read result carries data")

	// SRAM data is only returned on decoded accesses.
	`KCBD_ASSERT_NOW(a_ram_read_handled, valid_s1 && ram_use_s1, m_tuser[0],
		"SRAM read result not marked handled")

	// A live halt request through the control port halts and rewinds the stream.
	`KCBD_ASSERT_NEXT(a_halt_clears_counter,
		accept && (s_tuser == kcbd_pkg::OP_HOST_WR) &&
		(s_tdata[15:0] == kcbd_pkg::PORT_HALT_CTRL) && !fm8_q && !s_tdata[23],
		state_q.halted && (state_q.cnt == 8'd0),
		"halt control did not halt and clear the counter")

endmodule
